// ----- src/vbw_pkg.sv -----
// Shared types and constants for the vertex bone weight slot table.
// Request and response word layouts, request and status codes.
// No dependencies.
package vbw_pkg;

  localparam int BONE_W       = 8;
  localparam int WEIGHT_W     = 17;
  localparam int SLOTS_DEF    = 4;
  localparam int VERTICES_DEF = 4096;
  localparam int MAX_BONES    = 256;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

  typedef logic [1:0] req_code_t;
  localparam req_code_t REQ_CLEAR = 2'd0;
  localparam req_code_t REQ_ADD   = 2'd1;
  localparam req_code_t REQ_READ  = 2'd2;

  typedef logic [2:0] status_t;
  localparam status_t STAT_CLEARED   = 3'd0;
  localparam status_t STAT_PLACED    = 3'd1;
  localparam status_t STAT_REPLACED  = 3'd2;
  localparam status_t STAT_DROPPED   = 3'd3;
  localparam status_t STAT_READ_DONE = 3'd4;

  typedef struct packed {
    req_code_t           req_type;
    logic [11:0]         vertex_id;
    logic [1:0]          slot_select;
    logic [BONE_W-1:0]   bone_id;
    logic [WEIGHT_W-1:0] weight;
  } req_word_t;

  typedef struct packed {
    status_t             status;
    logic [1:0]          slot_index;
    logic                slot_used;
    logic [BONE_W-1:0]   slot_bone;
    logic [WEIGHT_W-1:0] slot_weight;
  } rsp_word_t;

endpackage

// ----- src/vbw_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module vbw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/vertex_bone_weight_slot_table.sv -----
// A request word is captured and its vertex word read from the RAM on accept; in the
// execute state, once the response slot is free, the result word is registered and the
// modified vertex word written back. Requests are taken one at a time.
// Reset: synchronous; a clearing pass over every address empties every vertex,
// req_ready stays low during it. A finished result may wait while the next is taken.
// Depends on vbw_pkg and vbw_ram.
module vertex_bone_weight_slot_table #(
  parameter int SLOTS    = vbw_pkg::SLOTS_DEF,
  parameter int VERTICES = vbw_pkg::VERTICES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  vbw_pkg::req_word_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output vbw_pkg::rsp_word_t rsp
);
  import vbw_pkg::*;

  localparam int AW     = $clog2(VERTICES);
  localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BONE_O = SLOTS;
  localparam int WGT_O  = SLOTS * (1 + BONE_W);
  localparam int WW     = SLOTS * (1 + BONE_W + WEIGHT_W);

  typedef enum logic [2:0] {
    ST_INIT = 3'b001,
    ST_IDLE = 3'b010,
    ST_EXEC = 3'b100
  } state_t;

  state_t    state, state_next;
  logic [AW-1:0] clr_addr;
  req_word_t r;
  req_word_t req_sat;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [WW-1:0] ram_wdata, ram_rdata;

  logic [AW+11:0] in_vid_ext, r_vid_ext;
  logic [AW-1:0]  r_addr;
  logic           accept, fire;

  // combinational result of the current request
  logic                wr_need;
  logic [WW-1:0]       word_new;
  rsp_word_t           rsp_next;
  logic [SLOTS-1:0]    used_v, used_n;
  logic [BONE_W-1:0]   bone_a [SLOTS];
  logic [WEIGHT_W-1:0] wgt_a  [SLOTS];
  logic [BONE_W-1:0]   bone_n [SLOTS];
  logic [WEIGHT_W-1:0] wgt_n  [SLOTS];
  logic                vok, bok, sel_ok;
  logic                has_empty, has_low;
  logic [SW-1:0]       empty_idx, pick;
  logic [WEIGHT_W-1:0] lowest;
  logic                sel_used;
  logic [BONE_W-1:0]   sel_bone;
  logic [WEIGHT_W-1:0] sel_wgt;

  assign accept     = req_valid && req_ready;
  assign req_ready  = (state == ST_IDLE);
  assign fire       = (state == ST_EXEC) && (!rsp_valid || rsp_ready);
  assign in_vid_ext = (AW+12)'(req.vertex_id);
  assign r_vid_ext  = (AW+12)'(r.vertex_id);
  assign r_addr     = r_vid_ext[AW-1:0];

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: if (clr_addr == AW'(VERTICES - 1)) state_next = ST_IDLE;
      ST_IDLE: if (accept) state_next = ST_EXEC;
      ST_EXEC: if (fire) state_next = ST_IDLE;
      default: state_next = ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_INIT) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // weight saturated to 1.0 before capture
  always_comb begin
    req_sat = req;
    if (req.weight > WEIGHT_ONE) begin
      req_sat.weight = WEIGHT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r <= req_sat;
    end
    if (fire) begin
      rsp <= rsp_next;
    end
  end

  assign ram_re    = accept;
  assign ram_raddr = in_vid_ext[AW-1:0];
  assign ram_we    = (state == ST_INIT) || (fire && wr_need);
  assign ram_waddr = (state == ST_INIT) ? clr_addr : r_addr;
  assign ram_wdata = (state == ST_INIT) ? '0 : word_new;

  vbw_ram #(
    .WIDTH(WW),
    .DEPTH(VERTICES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    used_v = ram_rdata[SLOTS-1:0];
    for (int i = 0; i < SLOTS; i++) begin
      bone_a[i] = ram_rdata[BONE_O + BONE_W*i +: BONE_W];
      wgt_a[i]  = ram_rdata[WGT_O + WEIGHT_W*i +: WEIGHT_W];
    end

    vok    = 32'(r.vertex_id) < VERTICES;
    bok    = 32'(r.bone_id) < MAX_BONES;
    sel_ok = 32'(r.slot_select) < SLOTS;

    // first empty slot
    has_empty = 1'b0;
    empty_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_v[i]) begin
        has_empty = 1'b1;
        empty_idx = SW'(i);
      end
    end

    // first slot holding the smallest weight below 1.0
    has_low = 1'b0;
    pick    = '0;
    lowest  = WEIGHT_ONE;
    for (int i = 0; i < SLOTS; i++) begin
      if (wgt_a[i] < lowest) begin
        lowest  = wgt_a[i];
        pick    = SW'(i);
        has_low = 1'b1;
      end
    end

    sel_used = 1'b0;
    sel_bone = '0;
    sel_wgt  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (32'(r.slot_select) == i && used_v[i]) begin
        sel_used = 1'b1;
        sel_bone = bone_a[i];
        sel_wgt  = wgt_a[i];
      end
    end

    used_n = used_v;
    for (int i = 0; i < SLOTS; i++) begin
      bone_n[i] = bone_a[i];
      wgt_n[i]  = wgt_a[i];
    end
    wr_need  = 1'b0;
    rsp_next = '{status: STAT_DROPPED, slot_index: '0, slot_used: 1'b0,
                 slot_bone: '0, slot_weight: '0};

    case (r.req_type)
      REQ_CLEAR: begin
        rsp_next.status = STAT_CLEARED;
        if (vok) begin
          wr_need = 1'b1;
          used_n  = '0;
        end
      end
      REQ_ADD: begin
        if (vok && bok) begin
          if (has_empty) begin
            wr_need               = 1'b1;
            used_n[empty_idx]     = 1'b1;
            bone_n[empty_idx]     = r.bone_id;
            wgt_n[empty_idx]      = r.weight;
            rsp_next.status       = STAT_PLACED;
            rsp_next.slot_index   = 2'(empty_idx);
          end else if (has_low && r.weight > lowest) begin
            wr_need               = 1'b1;
            bone_n[pick]          = r.bone_id;
            wgt_n[pick]           = r.weight;
            rsp_next.status       = STAT_REPLACED;
            rsp_next.slot_index   = 2'(pick);
            rsp_next.slot_bone    = bone_a[pick];
            rsp_next.slot_weight  = wgt_a[pick];
          end
        end
      end
      REQ_READ: begin
        rsp_next.status     = STAT_READ_DONE;
        rsp_next.slot_index = r.slot_select;
        if (vok && sel_ok && sel_used) begin
          rsp_next.slot_used   = 1'b1;
          rsp_next.slot_bone   = sel_bone;
          rsp_next.slot_weight = sel_wgt;
        end
      end
      default: ;
    endcase

    word_new = '0;
    word_new[SLOTS-1:0] = used_n;
    for (int i = 0; i < SLOTS; i++) begin
      word_new[BONE_O + BONE_W*i +: BONE_W]  = bone_n[i];
      word_new[WGT_O + WEIGHT_W*i +: WEIGHT_W] = wgt_n[i];
    end
  end

endmodule

// ----- src/vbw_checker.sv -----
// Port-level checks for the vertex bone weight slot table, with its bind.
// Depends on vbw_pkg.
module vbw_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input vbw_pkg::req_word_t req,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input vbw_pkg::rsp_word_t rsp
);
  import vbw_pkg::*;

  // a pending response word holds until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response word changed or dropped while stalled");

  // one request at a time: ready drops after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while previous one in flight");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status <= STAT_READ_DONE)
    else $error("undefined status code");

  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == STAT_CLEARED || rsp.status == STAT_DROPPED) |->
      rsp.slot_index == '0 && !rsp.slot_used && rsp.slot_bone == '0 &&
      rsp.slot_weight == '0)
    else $error("clear or drop word carries slot data");

  // evicted weight is always strictly below 1.0
  a_evict_below_one: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == STAT_REPLACED |-> rsp.slot_weight < WEIGHT_ONE)
    else $error("evicted weight not below 1.0");

endmodule

bind vertex_bone_weight_slot_table vbw_checker u_vbw_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_ready(req_ready),
  .req      (req),
  .rsp_valid(rsp_valid),
  .rsp_ready(rsp_ready),
  .rsp      (rsp)
);

// ----- tb/tb.sv -----
// Self-checking testbench for vertex_bone_weight_slot_table: directed words, then
// biased random words under three idle/stall mixes, each checked against a slot predictor.
// Depends on vbw_pkg and the block's RTL.
module tb;
  import vbw_pkg::*;

  localparam req_code_t REQ_UNKNOWN = 2'd3;
  localparam int SLOT_COUNT = SLOTS_DEF;
  localparam int PHASE_WORDS = 480;

  typedef struct {
    req_word_t word;
    bit        typed;
    rsp_word_t result;
  } script_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_word_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_word_t rsp;

  // predictor copy of the slot table
  logic [SLOT_COUNT-1:0] used_mask [VERTICES_DEF];
  logic [BONE_W-1:0]     bone_mem [VERTICES_DEF][SLOT_COUNT];
  logic [WEIGHT_W-1:0]   wt_mem [VERTICES_DEF][SLOT_COUNT];

  rsp_word_t   queued_slot_results [$];
  script_row_t script [$];
  logic [11:0] hot_vertex [8];

  int errors = 0;
  int words_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cleared_cnt = 0, placed_cnt = 0, replaced_cnt = 0, dropped_cnt = 0;
  int read_cnt = 0, read_hit_cnt = 0;

  vertex_bone_weight_slot_table dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic rsp_word_t update_slot_table(input req_word_t w);
    rsp_word_t           r;
    logic [WEIGHT_W-1:0] wt;
    logic [WEIGHT_W-1:0] lowest;
    logic [1:0]          pick;
    bit                  found;
    bit                  placed;
    logic [11:0]         v;
    r = '0;
    v = w.vertex_id;
    wt = (w.weight > WEIGHT_ONE) ? WEIGHT_ONE : w.weight;
    case (w.req_type)
      REQ_CLEAR: begin
        used_mask[v] = '0;
        r.status = STAT_CLEARED;
      end
      REQ_ADD: begin
        r.status = STAT_DROPPED;
        placed = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!placed && !used_mask[v][i]) begin
            used_mask[v][i] = 1'b1;
            bone_mem[v][i] = w.bone_id;
            wt_mem[v][i] = wt;
            r.status = STAT_PLACED;
            r.slot_index = i[1:0];
            placed = 1'b1;
          end
        end
        if (!placed) begin
          // full: first slot holding the strictly smallest weight below 1.0
          lowest = WEIGHT_ONE;
          pick = '0;
          found = 1'b0;
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (wt_mem[v][i] < lowest) begin
              lowest = wt_mem[v][i];
              pick = i[1:0];
              found = 1'b1;
            end
          end
          if (found && wt > lowest) begin
            r.status = STAT_REPLACED;
            r.slot_index = pick;
            r.slot_bone = bone_mem[v][pick];
            r.slot_weight = lowest;
            bone_mem[v][pick] = w.bone_id;
            wt_mem[v][pick] = wt;
          end
        end
      end
      REQ_READ: begin
        r.status = STAT_READ_DONE;
        r.slot_index = w.slot_select;
        if (used_mask[v][w.slot_select]) begin
          r.slot_used = 1'b1;
          r.slot_bone = bone_mem[v][w.slot_select];
          r.slot_weight = wt_mem[v][w.slot_select];
        end
      end
      default: r.status = STAT_DROPPED;
    endcase
    return r;
  endfunction

  function automatic void add_step(input req_code_t t, input int v, input int s, input int b,
                                   input int w, input bit typed, input status_t st = STAT_CLEARED,
                                   input int idx = 0, input bit used = 1'b0, input int bone = 0,
                                   input int wt = 0);
    script_row_t row;
    row.word.req_type = t;
    row.word.vertex_id = 12'(v);
    row.word.slot_select = 2'(s);
    row.word.bone_id = 8'(b);
    row.word.weight = 17'(w);
    row.typed = typed;
    row.result.status = st;
    row.result.slot_index = 2'(idx);
    row.result.slot_used = used;
    row.result.slot_bone = 8'(bone);
    row.result.slot_weight = 17'(wt);
    script.insert(script.size(), row);
  endfunction

  function automatic req_word_t random_request();
    req_word_t   w;
    int unsigned roll;
    w.vertex_id = ($urandom_range(99) < 85) ? hot_vertex[3'($urandom_range(7))]
                                              : 12'($urandom);
    w.slot_select = 2'($urandom_range(3));
    w.bone_id = 8'($urandom_range(255));
    case ($urandom_range(9))
      0: w.weight = '0;
      1: w.weight = WEIGHT_ONE;
      2: w.weight = 17'($urandom_range(131071, 65537));
      3, 4: w.weight = 17'($urandom_range(255));
      default: w.weight = 17'($urandom_range(65536));
    endcase
    roll = $urandom_range(99);
    if (roll < 6) w.req_type = REQ_CLEAR;
    else if (roll < 56) w.req_type = REQ_ADD;
    else if (roll < 96) w.req_type = REQ_READ;
    else w.req_type = REQ_UNKNOWN;
    return w;
  endfunction

  // Called in the step of an edge; returns in the step of the accepting edge
  // with req_valid still high.
  task automatic send_word(input req_word_t w, input bit typed, input rsp_word_t typed_rsp);
    rsp_word_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= w;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predicted = update_slot_table(w);
    queued_slot_results.insert(queued_slot_results.size(), typed ? typed_rsp : predicted);
    words_sent++;
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    do @(posedge clk); while (queued_slot_results.size() != 0);
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // receiver: random stall and result checking
  always @(posedge clk) begin
    rsp_word_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (queued_slot_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, got %h", $time, rsp);
      end else begin
        want = queued_slot_results.pop_front();
        check_field("status", want.status, rsp.status);
        check_field("slot_index", want.slot_index, rsp.slot_index);
        check_field("slot_used", want.slot_used, rsp.slot_used);
        check_field("slot_bone", want.slot_bone, rsp.slot_bone);
        check_field("slot_weight", want.slot_weight, rsp.slot_weight);
        case (rsp.status)
          STAT_CLEARED: cleared_cnt++;
          STAT_PLACED: placed_cnt++;
          STAT_REPLACED: replaced_cnt++;
          STAT_DROPPED: dropped_cnt++;
          STAT_READ_DONE: begin
            read_cnt++;
            if (rsp.slot_used) read_hit_cnt++;
          end
          default: ;
        endcase
      end
    end
    rsp_ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    int guard;
    for (int i = 0; i < VERTICES_DEF; i++) used_mask[i] = '0;
    for (int i = 0; i < 8; i++) hot_vertex[i] = 12'($urandom);

    // after reset, extremes of every field
    add_step(REQ_READ, 0, 0, 0, 0, 1, STAT_READ_DONE, 0);
    add_step(REQ_READ, 4095, 3, 255, 131071, 1, STAT_READ_DONE, 3);
    add_step(REQ_CLEAR, 4095, 3, 255, 131071, 1, STAT_CLEARED);
    add_step(REQ_ADD, 4095, 0, 0, 0, 1, STAT_PLACED, 0);
    add_step(REQ_ADD, 4095, 0, 255, 65536, 1, STAT_PLACED, 1);
    add_step(REQ_ADD, 4095, 3, 17, 131071, 1, STAT_PLACED, 2);   // saturates to 1.0
    add_step(REQ_ADD, 4095, 0, 200, 65535, 1, STAT_PLACED, 3);
    add_step(REQ_ADD, 4095, 0, 5, 0, 1, STAT_DROPPED);           // equal weight, no swap
    add_step(REQ_ADD, 4095, 0, 6, 1, 1, STAT_REPLACED, 0, 0, 0, 0);
    add_step(REQ_READ, 4095, 2, 0, 0, 1, STAT_READ_DONE, 2, 1, 17, 65536);
    add_step(REQ_READ, 4095, 0, 0, 0, 1, STAT_READ_DONE, 0, 1, 6, 1);
    add_step(REQ_UNKNOWN, 4095, 3, 255, 131071, 1, STAT_DROPPED);
    add_step(REQ_CLEAR, 4095, 0, 0, 0, 1, STAT_CLEARED);
    add_step(REQ_READ, 4095, 1, 0, 0, 1, STAT_READ_DONE, 1);     // cleared slot reads empty
    // every slot at 1.0: nothing qualifies
    for (int i = 0; i < 4; i++) add_step(REQ_ADD, 0, 0, i + 1, 65536, 1, STAT_PLACED, i);
    add_step(REQ_ADD, 0, 0, 9, 131071, 1, STAT_DROPPED);
    add_step(REQ_READ, 0, 3, 0, 0, 1, STAT_READ_DONE, 3, 1, 4, 65536);
    // tie on the smallest weight: first one goes
    add_step(REQ_CLEAR, 1, 0, 0, 0, 0);
    add_step(REQ_ADD, 1, 0, 10, 100, 0);
    add_step(REQ_ADD, 1, 0, 11, 50, 0);
    add_step(REQ_ADD, 1, 0, 12, 50, 0);
    add_step(REQ_ADD, 1, 0, 13, 200, 0);
    add_step(REQ_ADD, 1, 0, 14, 60, 0);
    add_step(REQ_READ, 1, 1, 0, 0, 0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) send_word(script[i].word, script[i].typed, script[i].result);
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 9;  recv_stall_pct = 62; end
        1: begin send_idle_pct = 62; recv_stall_pct = 9;  end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) send_word(random_request(), 1'b0, '0);
      // hold off until the block has answered everything
      drain_results();
    end

    req_valid <= 1'b0;
    guard = 0;
    while (queued_slot_results.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (queued_slot_results.size() != 0) begin
      errors += queued_slot_results.size();
      $display("%0t: %0d expected words never arrived", $time, queued_slot_results.size());
    end

    $display("Sent %0d request words: %0d clears, %0d placed, %0d replaced, %0d dropped,",
             words_sent, cleared_cnt, placed_cnt, replaced_cnt, dropped_cnt);
    $display("%0d reads (%0d of used slots), under three idle/stall mixes.",
             read_cnt, read_hit_cnt);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
